>>> rtl/core/dtbs_pkg.sv
// Shared types, constants and helpers for the date table search block.
`default_nettype none

package dtbs_pkg;

  localparam int DATE_W  = 23;
  localparam int CNT_W   = 9;
  localparam int SLOT_W  = 8;
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  // Search bounds hold up to 511 plus headroom for mid + bound sums.
  localparam int BND_W   = CNT_W + 1;

  localparam int DEFAULT_TABLE_DEPTH = 256;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef logic [DATE_W-1:0] date_t;
  typedef logic [BND_W-1:0]  bound_t;

  // Packed order makes one unsigned compare equal year, month, day order.
  function automatic date_t pack_date(logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
                                      logic [YEAR_W-1:0] y);
    return {y, m, d};
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/dtbs_mem.sv
// Date table storage: one write port, one registered read port.
`default_nettype none

module dtbs_mem #(
  parameter int TABLE_DEPTH = dtbs_pkg::DEFAULT_TABLE_DEPTH,
  parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
  input  wire                        clk,
  input  wire                        wr_en,
  input  wire [ADDR_W-1:0]           wr_addr,
  input  wire dtbs_pkg::date_t       wr_data,
  input  wire                        rd_en,
  input  wire [ADDR_W-1:0]           rd_addr,
  output dtbs_pkg::date_t            rd_data
);
  import dtbs_pkg::*;

  date_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/dtbs_ctrl.sv
// Search sequencer: accepts items, drives table writes and probes, holds the result.
`default_nettype none

module dtbs_ctrl #(
  parameter int TABLE_DEPTH = dtbs_pkg::DEFAULT_TABLE_DEPTH,
  parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_valid,
  input  wire [dtbs_pkg::CNT_W-1:0]    cfg_data,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          req_type,
  input  wire [dtbs_pkg::SLOT_W-1:0]   slot_index,
  input  wire dtbs_pkg::date_t         key_in,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         found,
  output logic [dtbs_pkg::SLOT_W-1:0]  match_slot,
  output logic                         wr_en,
  output logic [ADDR_W-1:0]            wr_addr,
  output dtbs_pkg::date_t              wr_data,
  output logic                         rd_en,
  output logic [ADDR_W-1:0]            rd_addr,
  input  wire dtbs_pkg::date_t         rd_data
);
  import dtbs_pkg::*;

  localparam logic [BND_W-1:0] COUNT_CAP =
      (TABLE_DEPTH > 511) ? BND_W'(511) : BND_W'(TABLE_DEPTH);
  localparam logic [SLOT_W:0] SLOT_CAP =
      (TABLE_DEPTH > 256) ? (SLOT_W+1)'(256) : (SLOT_W+1)'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_DONE
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    entry_count;
  date_t               key;
  bound_t              low;
  bound_t              hi_ex;   // exclusive upper bound
  bound_t              mid;
  logic                res_found;
  logic [SLOT_W-1:0]   res_slot;

  bound_t              count;
  bound_t              mid_first;
  bound_t              sum_r;
  bound_t              sum_l;
  bound_t              mid_r;
  bound_t              mid_l;
  logic                cont_r;
  logic                cont_l;
  logic                is_eq;
  logic                is_lt;
  logic                accept;
  logic                start_search;
  bound_t              next_mid;

  always_comb begin
    count = ({1'b0, entry_count} > COUNT_CAP) ? COUNT_CAP : {1'b0, entry_count};
    mid_first = (count - BND_W'(1)) >> 1;
    // Both successor probes are formed alongside the compare; the compare picks one.
    sum_r  = mid + hi_ex;
    mid_r  = sum_r >> 1;
    cont_r = (mid + BND_W'(1)) < hi_ex;
    sum_l  = low + mid - BND_W'(1);
    mid_l  = sum_l >> 1;
    cont_l = low < mid;
    is_eq  = (rd_data == key);
    is_lt  = (rd_data < key);

    in_ready     = (state == ST_IDLE);
    accept       = in_valid && in_ready;
    start_search = accept && (req_type == REQ_SEARCH) && (count != '0);

    wr_en   = accept && (req_type == REQ_WRITE) && ({1'b0, slot_index} < SLOT_CAP);
    wr_addr = ADDR_W'(slot_index);
    wr_data = key_in;

    next_mid = mid_first;
    rd_en    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        next_mid = mid_first;
        rd_en    = start_search;
      end
      ST_CMP: begin
        next_mid = is_lt ? mid_r : mid_l;
        rd_en    = !is_eq && (is_lt ? cont_r : cont_l);
      end
      ST_DONE: begin
        next_mid = mid_first;
        rd_en    = 1'b0;
      end
      default: begin
        next_mid = mid_first;
        rd_en    = 1'b0;
      end
    endcase
    rd_addr = ADDR_W'(next_mid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      out_valid   <= 1'b0;
      res_found   <= 1'b0;
      res_slot    <= '0;
      found       <= 1'b0;
      match_slot  <= '0;
    end else begin
      if (cfg_valid) begin
        entry_count <= cfg_data;
      end
      // Load a waiting result, else drop the item once it is taken.
      if ((state == ST_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && (req_type == REQ_SEARCH)) begin
            key       <= key_in;
            low       <= '0;
            hi_ex     <= count;
            mid       <= mid_first;
            res_found <= 1'b0;
            res_slot  <= '0;
            state     <= start_search ? ST_CMP : ST_DONE;
          end
        end
        ST_CMP: begin
          if (is_eq) begin
            res_found <= 1'b1;
            res_slot  <= mid[SLOT_W-1:0];
            state     <= ST_DONE;
          end else if (is_lt) begin
            low <= mid + BND_W'(1);
            mid <= mid_r;
            if (!cont_r) begin
              state <= ST_DONE;
            end
          end else begin
            hi_ex <= mid;
            mid   <= mid_l;
            if (!cont_l) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          // Hold the result until the output register frees up.
          if (!out_valid || out_ready) begin
            found      <= res_found;
            match_slot <= res_slot;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/date_table_binary_search.sv
// Top level: date table with binary search over the sorted entries.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------
//   cfg     | cfg_valid/cfg_ready  | cfg_data (entry_count, 9 bits)
//   in      | in_valid/in_ready    | req_type, slot_index, day, month, year
//   out     | out_valid/out_ready  | found, match_slot
//
// A write item is written to the table as it is accepted. A search item issues the first
// table read as it is accepted, then makes probes of one table read each (at most 9 at 256
// entries) and then loads the output register; a search of an empty table skips the probes.
// Reset clears the entry count and the control state; the table itself is not cleared.
// A result that waits on out_ready stalls the search in its final state; in_ready
// returns once the result moves into the output register.
`default_nettype none

module date_table_binary_search #(
  parameter int TABLE_DEPTH = dtbs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [dtbs_pkg::CNT_W-1:0]     cfg_data,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire                           req_type,
  input  wire [dtbs_pkg::SLOT_W-1:0]    slot_index,
  input  wire [dtbs_pkg::DAY_W-1:0]     day,
  input  wire [dtbs_pkg::MONTH_W-1:0]   month,
  input  wire [dtbs_pkg::YEAR_W-1:0]    year,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic                          found,
  output logic [dtbs_pkg::SLOT_W-1:0]   match_slot
);
  import dtbs_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  date_t               key_in;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  date_t               wr_data;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  date_t               rd_data;

  assign cfg_ready = 1'b1;
  assign key_in    = pack_date(day, month, year);

  dtbs_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .slot_index (slot_index),
    .key_in     (key_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found      (found),
    .match_slot (match_slot),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  dtbs_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

>>> verif/date_table_binary_search_test.sv
// Testbench for the date table search block: queued writes, searches and count updates.
`timescale 1ns / 100ps

module date_table_binary_search_test;
  import dtbs_pkg::*;

  localparam int TABLE_DEPTH    = 256;
  localparam int RESET_CYCLES   = 6;
  localparam int IDLE_PCT       = 37;
  localparam int SETTLE_CYCLES  = 16;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int ITEM_TARGET    = 600;
  localparam int COUNT_MAX      = (1 << CNT_W) - 1;

  typedef enum bit {OP_ITEM, OP_CFG} op_kind_t;

  typedef struct {
    op_kind_t            kind;
    logic                req;
    logic [SLOT_W-1:0]   slot;
    date_t               date;
    logic [CNT_W-1:0]    count;
  } op_t;

  typedef struct {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } search_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CNT_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 req_type = REQ_WRITE;
  logic [SLOT_W-1:0]    slot_index = '0;
  logic [DAY_W-1:0]     day = '0;
  logic [MONTH_W-1:0]   month = '0;
  logic [YEAR_W-1:0]    year = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 found;
  logic [SLOT_W-1:0]    match_slot;

  op_t             pending_ops[$];
  search_result_t  awaited_results[$];

  // stimulus-side view of the table, used only to pick keys
  date_t           shadow_dates[TABLE_DEPTH];
  int              shadow_count = 0;
  int              items_queued = 0;

  // predictor state, updated on accepted items and count writes
  date_t           stored_dates[TABLE_DEPTH];
  int              stored_count = 0;

  bit              in_acc = 1'b0;
  bit              out_acc = 1'b0;
  bit              cfg_acc = 1'b0;
  int              idle_cycles = 0;
  int              items_driven = 0;
  int              results_seen = 0;
  int              mismatches = 0;
  op_t             next_op;
  bit              launched;
  search_result_t  want;

  date_table_binary_search #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .slot_index (slot_index),
    .day        (day),
    .month      (month),
    .year       (year),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found      (found),
    .match_slot (match_slot)
  );

  always #6 clk = ~clk;

  function automatic search_result_t lookup_date(date_t key);
    search_result_t r;
    int lo;
    int hi;
    int mid;
    r.found = 1'b0;
    r.slot = '0;
    lo = 0;
    hi = ((stored_count > TABLE_DEPTH) ? TABLE_DEPTH : stored_count) - 1;
    while (lo <= hi && !r.found) begin
      mid = (lo + hi) / 2;
      if (stored_dates[mid] == key) begin
        r.found = 1'b1;
        r.slot = SLOT_W'(mid);
      end else if (stored_dates[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return r;
  endfunction

  task automatic add_write(input int slot, input date_t d);
    op_t op;
    op.kind = OP_ITEM;
    op.req = REQ_WRITE;
    op.slot = SLOT_W'(slot);
    op.date = d;
    op.count = '0;
    pending_ops.push_back(op);
    shadow_dates[slot] = d;
    items_queued++;
  endtask

  task automatic add_search(input date_t d);
    op_t op;
    op.kind = OP_ITEM;
    op.req = REQ_SEARCH;
    op.slot = SLOT_W'($urandom_range(0, TABLE_DEPTH - 1));
    op.date = d;
    op.count = '0;
    pending_ops.push_back(op);
    items_queued++;
  endtask

  task automatic add_count(input int n);
    op_t op;
    op.kind = OP_CFG;
    op.req = REQ_WRITE;
    op.slot = '0;
    op.date = '0;
    op.count = CNT_W'(n);
    pending_ops.push_back(op);
    shadow_count = n;
  endtask

  // Mostly stored dates, then near misses, then anything.
  function automatic date_t pick_key();
    int live;
    int r;
    date_t e;
    live = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : shadow_count;
    r = $urandom_range(0, 99);
    if (live == 0 || r >= 80)
      return DATE_W'($urandom);
    e = shadow_dates[$urandom_range(0, live - 1)];
    if (r < 60)
      return e;
    return $urandom_range(0, 1) ? DATE_W'(e + 1) : DATE_W'(e - 1);
  endfunction

  // Fill slots 0..n-1 in ascending order, with some repeated dates.
  task automatic load_sorted(input int n);
    int unsigned base;
    int unsigned step_max;
    int unsigned v;
    int i;
    base = $urandom_range(0, 1 << (DATE_W - 1));
    step_max = ((1 << DATE_W) - 1 - base) / n;
    v = base;
    for (i = 0; i < n; i++) begin
      add_write(i, DATE_W'(v));
      if ($urandom_range(0, 4) != 0)
        v += $urandom_range(1, step_max);
    end
  endtask

  task automatic run_searches(input int k);
    int i;
    for (i = 0; i < k; i++) begin
      // stray writes leave the table unsorted, which is still legal
      if (shadow_count > 0 && $urandom_range(0, 9) == 0)
        add_write($urandom_range(0, TABLE_DEPTH - 1), DATE_W'($urandom));
      else
        add_search(pick_key());
    end
  endtask

  // Sample handshakes, predict and check.
  always @(posedge clk) begin
    if (rst) begin
      in_acc = 1'b0;
      out_acc = 1'b0;
      cfg_acc = 1'b0;
    end else begin
      in_acc = in_valid && in_ready;
      out_acc = out_valid && out_ready;
      cfg_acc = cfg_valid && cfg_ready;
      if (cfg_acc)
        stored_count = cfg_data;
      if (in_acc) begin
        if (req_type == REQ_WRITE)
          stored_dates[slot_index] = {year, month, day};
        else
          awaited_results.push_back(lookup_date({year, month, day}));
      end
      if (out_acc) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result found=%0b match_slot=%0d", $time, found,
                   match_slot);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (found !== want.found) begin
            $display("%0t: found expected %0b got %0b", $time, want.found, found);
            mismatches++;
          end
          if (match_slot !== want.slot) begin
            $display("%0t: match_slot expected %0d got %0d", $time, want.slot, match_slot);
            mismatches++;
          end
        end
      end
      if (in_acc || out_acc || cfg_acc)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("date_table_binary_search_test: errors");
        $finish;
      end
    end
  end

  // Drive items and count writes at the falling edge.
  always @(negedge clk) begin
    if (!rst) begin
      launched = 1'b0;
      if (!in_valid || in_acc) begin
        if (pending_ops.size() > 0 && pending_ops[0].kind == OP_ITEM &&
            !(cfg_valid && !cfg_acc) &&
            ((items_driven >= 300 && items_driven < 400) ||
             $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_op = pending_ops.pop_front();
          in_valid <= 1'b1;
          req_type <= next_op.req;
          slot_index <= next_op.slot;
          {year, month, day} <= next_op.date;
          items_driven++;
          launched = 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      // Hold count writes until the block has settled with nothing in flight.
      if (cfg_valid && cfg_acc) begin
        cfg_valid <= 1'b0;
      end else if (!cfg_valid && !launched && !in_valid && pending_ops.size() > 0 &&
                   pending_ops[0].kind == OP_CFG && awaited_results.size() == 0 &&
                   idle_cycles >= SETTLE_CYCLES) begin
        next_op = pending_ops.pop_front();
        cfg_valid <= 1'b1;
        cfg_data <= next_op.count;
      end
      out_ready <= (results_seen >= 120 && results_seen < 180) ||
                   $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  initial begin
    // empty table
    add_search('0);
    add_search({YEAR_W'('1), MONTH_W'('1), DAY_W'('1)});
    // small table with a repeated date and both extremes
    add_write(0, '0);
    add_write(1, {YEAR_W'(2000), MONTH_W'(3), DAY_W'(5)});
    add_write(2, {YEAR_W'(2000), MONTH_W'(3), DAY_W'(5)});
    add_write(3, {YEAR_W'('1), MONTH_W'('1), DAY_W'('1)});
    add_write(TABLE_DEPTH - 1, {YEAR_W'(9999), MONTH_W'(6), DAY_W'(17)});
    add_count(4);
    add_search('0);
    add_search({YEAR_W'(2000), MONTH_W'(3), DAY_W'(5)});
    add_search({YEAR_W'('1), MONTH_W'('1), DAY_W'('1)});
    add_search({YEAR_W'(2000), MONTH_W'(3), DAY_W'(6)});
    add_search({YEAR_W'(2000), MONTH_W'(3), DAY_W'(4)});
    add_search({YEAR_W'(2001), MONTH_W'(0), DAY_W'(0)});
    add_count(1);
    add_search('0);
    add_search({YEAR_W'(2000), MONTH_W'(3), DAY_W'(5)});
    add_count(2);
    add_search({YEAR_W'(2000), MONTH_W'(3), DAY_W'(5)});

    // full table, then counts above the depth
    load_sorted(TABLE_DEPTH);
    add_count(TABLE_DEPTH);
    run_searches(40);
    add_count(COUNT_MAX);
    run_searches(15);
    add_count($urandom_range(TABLE_DEPTH + 1, COUNT_MAX - 1));
    run_searches(10);
    // every slot is written from here on, so any count is safe
    while (items_queued < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: begin
          add_count(0);
          run_searches(3);
        end
        1: begin
          add_count($urandom_range(0, COUNT_MAX));
          run_searches(8);
        end
        default: begin
          shadow_count = $urandom_range(1, 24);
          load_sorted(shadow_count);
          add_count(shadow_count);
          run_searches(shadow_count + $urandom_range(2, 10));
        end
      endcase
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (pending_ops.size() > 0 || in_valid || cfg_valid || awaited_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("date_table_binary_search_test: clean");
    else
      $display("date_table_binary_search_test: errors");
    $finish;
  end

endmodule

>>> date_table_binary_search.f
rtl/core/dtbs_pkg.sv
rtl/core/dtbs_mem.sv
rtl/core/dtbs_ctrl.sv
rtl/core/date_table_binary_search.sv
verif/date_table_binary_search_test.sv
